// File: rtl/flsf_pkg.sv
// Package for the folded literal substring finder.
// Holds sizing constants, register indexes, the match configuration struct
// and the ASCII case folding function. No dependencies.
package flsf_pkg;

	localparam int MAX_NEEDLE       = 16;
	localparam int OFFSET_BITS      = 16;
	localparam int LINE_BITS        = 20;
	localparam int LEN_BITS         = 5;
	localparam int RUN_BITS         = $clog2(MAX_NEEDLE + 1);
	localparam int NEEDLE_REG_BYTES = 16;
	localparam int NEEDLE_IDX_BITS  = 4;
	localparam int CFG_DATA_BITS    = 64;
	localparam int CFG_INDEX_BITS   = 2;

	localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

	typedef logic [7:0] byte_t;

	localparam byte_t CHAR_UPPER_A = 8'h41;
	localparam byte_t CHAR_UPPER_Z = 8'h5A;
	localparam byte_t CASE_DELTA   = 8'h20;

	localparam logic [CFG_INDEX_BITS-1:0] REG_NEEDLE_LOW  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_NEEDLE_HIGH = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_NEEDLE_LEN  = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CASE_SENS   = 2'd3;

	// Needle bytes, clamped length and fold enable for the compare unit
	typedef struct packed {
		byte_t [NEEDLE_REG_BYTES-1:0] needle;
		logic [RUN_BITS-1:0]          len;
		logic                         fold;
	} match_cfg_t;

	// Map A-Z to a-z when folding; every other byte passes unchanged
	function automatic byte_t fold_byte(byte_t b, logic fold);
		if (fold && (b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) begin
			return b + CASE_DELTA;
		end
		return b;
	endfunction

endpackage

// File: rtl/flsf_match.sv
// Window compare for the folded literal substring finder.
// Checks the newest needle-length window bytes against the needle in parallel.
// Depends on flsf_pkg.
module flsf_match (
	input  flsf_pkg::match_cfg_t                          cfg,
	input  flsf_pkg::byte_t [flsf_pkg::MAX_NEEDLE-1:0]    window,
	output logic                                          hit
);
	import flsf_pkg::*;

	logic [RUN_BITS-1:0] idx;
	byte_t               aligned;

	// Window entry j (newest is 0) lines up with needle byte len-1-j
	always_comb begin
		hit     = (cfg.len != '0);
		idx     = '0;
		aligned = '0;
		for (int j = 0; j < MAX_NEEDLE; j++) begin
			if (RUN_BITS'(j) < cfg.len) begin
				idx     = cfg.len - RUN_BITS'(1) - RUN_BITS'(j);
				aligned = cfg.needle[idx[NEEDLE_IDX_BITS-1:0]];
				if (fold_byte(window[j], cfg.fold) != fold_byte(aligned, cfg.fold)) begin
					hit = 1'b0;
				end
			end
		end
	end

endmodule

// File: rtl/folded_literal_substring_finder.sv
// Top level of the folded literal substring finder.
// Holds the configuration registers, the input stage, line state and the
// result register. Depends on flsf_pkg and flsf_match.
//
// Usage:
//   Text enters one byte per beat on the in channel (valid/ready). An item
//   with byte_present low carries no byte, as for an empty line; line_end
//   closes the line after the item, search_start restarts line numbering
//   before it. Each beat yields zero or one match on the out channel,
//   reported on the beat that supplies the match's last byte.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data),
//   which the user must write only while idle; the block does not enforce it.
//   Path: a match is valid on out once its input beat has passed the input
//   stage, the window compare and the result register.
//   Throughput: one beat per cycle while out is not stalled, set by the
//   combinational window compare between input stage and result register.
//   Stall: while a result waits for out_ready, one more beat is held in the
//   input stage; after that in_ready drops until the result is taken.
//   Reset: clears both stages, the line state and the line counter; the
//   needle is empty (no matches) and matching is case sensitive.
module folded_literal_substring_finder (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [flsf_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [flsf_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [7:0]                             data_byte,
	input  logic                                   byte_present,
	input  logic                                   line_end,
	input  logic                                   search_start,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [flsf_pkg::LINE_BITS-1:0]         line_number,
	output logic [flsf_pkg::OFFSET_BITS-1:0]       match_start,
	output logic [flsf_pkg::OFFSET_BITS-1:0]       match_end,
	output logic                                   position_overflow
);
	import flsf_pkg::*;

	// Configuration registers
	logic [CFG_DATA_BITS-1:0] needle_low_q;
	logic [CFG_DATA_BITS-1:0] needle_high_q;
	logic [LEN_BITS-1:0]      needle_len_q;
	logic                     case_sens_q;

	// Input stage
	logic  valid_s1;
	byte_t data_s1;
	logic  present_s1;
	logic  last_s1;
	logic  restart_s1;

	// Line state
	byte_t [MAX_NEEDLE-1:0]  window_q;
	logic [OFFSET_BITS-1:0]  bytes_q;
	logic [LINE_BITS-1:0]    line_q;
	logic                    ovf_q;
	logic [RUN_BITS-1:0]     run_q;

	// Result register
	logic                   out_valid_q;
	logic [LINE_BITS-1:0]   line_number_q;
	logic [OFFSET_BITS-1:0] match_start_q;
	logic [OFFSET_BITS-1:0] match_end_q;
	logic                   ovf_out_q;

	logic                   adv;
	match_cfg_t             mcfg;
	byte_t [MAX_NEEDLE-1:0] window_next;
	logic                   hit_raw;
	logic                   hit;
	logic [LINE_BITS-1:0]   line_base;
	logic [OFFSET_BITS-1:0] bytes_base;
	logic [OFFSET_BITS-1:0] bytes_next;
	logic                   ovf_base;
	logic                   ovf_next;
	logic [RUN_BITS-1:0]    run_base;
	logic [RUN_BITS-1:0]    run_next;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_low_q  <= '0;
			needle_high_q <= '0;
			needle_len_q  <= '0;
			case_sens_q   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NEEDLE_LOW:  needle_low_q  <= cfg_data;
				REG_NEEDLE_HIGH: needle_high_q <= cfg_data;
				REG_NEEDLE_LEN:  needle_len_q  <= cfg_data[LEN_BITS-1:0];
				REG_CASE_SENS:   case_sens_q   <= cfg_data[0];
				default:         needle_len_q  <= needle_len_q;
			endcase
		end
	end

	// Clamp the needle length and pack the compare configuration
	always_comb begin
		mcfg.needle = {needle_high_q, needle_low_q};
		mcfg.fold   = !case_sens_q;
		if (needle_len_q > LEN_BITS'(MAX_NEEDLE)) begin
			mcfg.len = RUN_BITS'(MAX_NEEDLE);
		end else begin
			mcfg.len = RUN_BITS'(needle_len_q);
		end
	end

	// Advance the input stage when the result register can take its outcome
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1    <= data_byte;
			present_s1 <= byte_present;
			last_s1    <= line_end;
			restart_s1 <= search_start;
		end
	end

	// Shift the new byte into the window
	always_comb begin
		window_next[0] = data_s1;
		for (int i = 1; i < MAX_NEEDLE; i++) begin
			window_next[i] = window_q[i-1];
		end
	end

	flsf_match u_match (
		.cfg    (mcfg),
		.window (window_next),
		.hit    (hit_raw)
	);

	// Restart first, then count the byte with saturation
	always_comb begin
		line_base  = restart_s1 ? '0 : line_q;
		bytes_base = restart_s1 ? '0 : bytes_q;
		ovf_base   = restart_s1 ? 1'b0 : ovf_q;
		run_base   = restart_s1 ? '0 : run_q;
		bytes_next = bytes_base;
		ovf_next   = ovf_base;
		run_next   = run_base;
		if (present_s1) begin
			if (bytes_base == OFFSET_MAX) begin
				ovf_next = 1'b1;
			end else begin
				bytes_next = bytes_base + OFFSET_BITS'(1);
			end
			if (run_base < RUN_BITS'(MAX_NEEDLE)) begin
				run_next = run_base + RUN_BITS'(1);
			end
		end
		hit = present_s1 && hit_raw && (run_next >= mcfg.len);
	end

	// Update line state; a line end clears it and bumps the line counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q <= '0;
			line_q  <= '0;
			ovf_q   <= 1'b0;
			run_q   <= '0;
		end else if (adv) begin
			if (last_s1) begin
				bytes_q <= '0;
				line_q  <= line_base + LINE_BITS'(1);
				ovf_q   <= 1'b0;
				run_q   <= '0;
			end else begin
				bytes_q <= bytes_next;
				line_q  <= line_base;
				ovf_q   <= ovf_next;
				run_q   <= hit ? '0 : run_next;
			end
		end
	end

	// Window entries are only read once run covers them, so no reset
	always_ff @(posedge clk) begin
		if (adv && present_s1) begin
			window_q <= window_next;
		end
	end

	// Load the result register; drop valid once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= hit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && hit) begin
			line_number_q <= line_base;
			match_end_q   <= bytes_next;
			match_start_q <= bytes_next - OFFSET_BITS'(mcfg.len);
			ovf_out_q     <= ovf_next;
		end
	end

	assign out_valid         = out_valid_q;
	assign line_number       = line_number_q;
	assign match_start       = match_start_q;
	assign match_end         = match_end_q;
	assign position_overflow = ovf_out_q;

	// A reported match always spans exactly the needle length
	a_match_span: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((match_end_q - match_start_q) == OFFSET_BITS'(mcfg.len)))
		else $error("match span differs from needle length");

	// The run counter never passes the needle capacity
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		run_q <= RUN_BITS'(MAX_NEEDLE))
		else $error("run counter out of range");

	// A hit needs a nonempty needle and a byte
	a_hit_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && hit) |-> ((mcfg.len != '0) && present_s1))
		else $error("hit without needle or byte");

	// A stalled input stage keeps its beat
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(data_s1) && $stable(last_s1)))
		else $error("input stage lost a stalled beat");

	// After a line end the next beat starts a fresh line
	a_line_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> ((bytes_q == '0) && (run_q == '0) && !ovf_q))
		else $error("line state not cleared at line end");

endmodule
